FILE: rtl/core/ortest_pkg.sv
// Shared widths, types and codes for the oriented rectangle overlap test.
package ortest_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_COORDS  = 2 * NUM_CORNERS;
  localparam int NUM_DIMS    = 2;

  // axis component: difference of two coordinates
  localparam int AXIS_WIDTH  = COORD_WIDTH + 1;
  // one coordinate times one axis component
  localparam int PROD_WIDTH  = COORD_WIDTH + AXIS_WIDTH;
  // two-term dot product
  localparam int DOT_WIDTH   = PROD_WIDTH + 1;
  // sum of four coordinates (four times the box center)
  localparam int SUM_WIDTH   = COORD_WIDTH + 2;
  // 4*c - sum and its magnitude
  localparam int HALF_WIDTH  = COORD_WIDTH + 3;
  // box edge at four times scale
  localparam int EDGE_WIDTH  = COORD_WIDTH + 4;

  // coordinate order inside a rectangle
  localparam int IDX_AX = 0;
  localparam int IDX_AY = 1;
  localparam int IDX_BX = 2;
  localparam int IDX_BY = 3;
  localparam int IDX_CX = 4;
  localparam int IDX_CY = 5;
  localparam int IDX_DX = 6;
  localparam int IDX_DY = 7;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [AXIS_WIDTH-1:0]  axis_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [DOT_WIDTH-1:0]   dot_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [HALF_WIDTH-1:0]  half_t;
  typedef logic signed [EDGE_WIDTH-1:0]  edge_t;

  // load enables of the pipeline stages that the lanes own
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } ortest_en_t;

endpackage

FILE: rtl/core/ortest_axis_lane.sv
// One separating-axis lane: builds an edge axis, projects all eight corners, checks spans.
module ortest_axis_lane (
  input  logic                   clk,
  input  ortest_pkg::ortest_en_t en,
  input  ortest_pkg::coord_t     p_x,
  input  ortest_pkg::coord_t     p_y,
  input  ortest_pkg::coord_t     q_x,
  input  ortest_pkg::coord_t     q_y,
  input  ortest_pkg::coord_t     ref_c [ortest_pkg::NUM_COORDS],
  input  ortest_pkg::coord_t     tst_c [ortest_pkg::NUM_COORDS],
  output logic                   sep
);

  ortest_pkg::axis_t ax_r, ay_r;
  ortest_pkg::dot_t  dot_r [ortest_pkg::NUM_COORDS];
  ortest_pkg::dot_t  dot_nxt [ortest_pkg::NUM_COORDS];
  ortest_pkg::prod_t prod_x [ortest_pkg::NUM_COORDS];
  ortest_pkg::prod_t prod_y [ortest_pkg::NUM_COORDS];
  logic              zero3_r, zero4_r;
  ortest_pkg::dot_t  rmin_r, rmax_r, tmin_r, tmax_r;
  ortest_pkg::dot_t  rmin_nxt, rmax_nxt, tmin_nxt, tmax_nxt;
  ortest_pkg::dot_t  lo_a, lo_b, hi_a, hi_b, lo_c, lo_d, hi_c, hi_d;
  logic              sep_r;

  // stage 2: edge axis
  always_ff @(posedge clk) begin
    if (en.s2) begin
      ax_r <= ortest_pkg::axis_t'(p_x) - ortest_pkg::axis_t'(q_x);
      ay_r <= ortest_pkg::axis_t'(p_y) - ortest_pkg::axis_t'(q_y);
    end
  end

  // stage 3: dot products, slots 0..3 reference corners, 4..7 tested corners
  always_comb begin
    for (int k = 0; k < ortest_pkg::NUM_CORNERS; k++) begin
      prod_x[k] = ref_c[2*k] * ax_r;
      prod_y[k] = ref_c[2*k+1] * ay_r;
      prod_x[k+ortest_pkg::NUM_CORNERS] = tst_c[2*k] * ax_r;
      prod_y[k+ortest_pkg::NUM_CORNERS] = tst_c[2*k+1] * ay_r;
    end
    for (int k = 0; k < ortest_pkg::NUM_COORDS; k++) begin
      dot_nxt[k] = ortest_pkg::dot_t'(prod_x[k]) + ortest_pkg::dot_t'(prod_y[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      dot_r   <= dot_nxt;
      zero3_r <= (ax_r == '0) && (ay_r == '0);
    end
  end

  // stage 4: span of each rectangle on the axis, two-level compare tree
  always_comb begin
    lo_a = (dot_r[1] < dot_r[0]) ? dot_r[1] : dot_r[0];
    lo_b = (dot_r[3] < dot_r[2]) ? dot_r[3] : dot_r[2];
    hi_a = (dot_r[1] > dot_r[0]) ? dot_r[1] : dot_r[0];
    hi_b = (dot_r[3] > dot_r[2]) ? dot_r[3] : dot_r[2];
    lo_c = (dot_r[5] < dot_r[4]) ? dot_r[5] : dot_r[4];
    lo_d = (dot_r[7] < dot_r[6]) ? dot_r[7] : dot_r[6];
    hi_c = (dot_r[5] > dot_r[4]) ? dot_r[5] : dot_r[4];
    hi_d = (dot_r[7] > dot_r[6]) ? dot_r[7] : dot_r[6];
    rmin_nxt = (lo_b < lo_a) ? lo_b : lo_a;
    rmax_nxt = (hi_b > hi_a) ? hi_b : hi_a;
    tmin_nxt = (lo_d < lo_c) ? lo_d : lo_c;
    tmax_nxt = (hi_d > hi_c) ? hi_d : hi_c;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      rmin_r  <= rmin_nxt;
      rmax_r  <= rmax_nxt;
      tmin_r  <= tmin_nxt;
      tmax_r  <= tmax_nxt;
      zero4_r <= zero3_r;
    end
  end

  // stage 5: touching spans still overlap; a zero-length axis never separates
  always_ff @(posedge clk) begin
    if (en.s5) begin
      sep_r <= !zero4_r && ((tmin_r > rmax_r) || (tmax_r < rmin_r));
    end
  end

  assign sep = sep_r;

endmodule

FILE: rtl/core/ortest_box_lane.sv
// Bounding-box rejection lane, kept at four times scale so it stays exact.
module ortest_box_lane (
  input  logic                   clk,
  input  ortest_pkg::ortest_en_t en,
  input  ortest_pkg::coord_t     ref1_c [ortest_pkg::NUM_COORDS],
  input  ortest_pkg::coord_t     tst1_c [ortest_pkg::NUM_COORDS],
  input  ortest_pkg::coord_t     ref2_c [ortest_pkg::NUM_COORDS],
  input  ortest_pkg::coord_t     tst2_c [ortest_pkg::NUM_COORDS],
  output logic                   sep
);

  // index [dim]: 0 = x, 1 = y
  ortest_pkg::sum_t  rsum2_r [ortest_pkg::NUM_DIMS];
  ortest_pkg::sum_t  tsum2_r [ortest_pkg::NUM_DIMS];
  ortest_pkg::sum_t  rsum3_r [ortest_pkg::NUM_DIMS];
  ortest_pkg::sum_t  tsum3_r [ortest_pkg::NUM_DIMS];
  ortest_pkg::sum_t  rsum_nxt [ortest_pkg::NUM_DIMS];
  ortest_pkg::sum_t  tsum_nxt [ortest_pkg::NUM_DIMS];
  ortest_pkg::half_t rhalf_r [ortest_pkg::NUM_DIMS];
  ortest_pkg::half_t thalf_r [ortest_pkg::NUM_DIMS];
  ortest_pkg::half_t rhalf_nxt [ortest_pkg::NUM_DIMS];
  ortest_pkg::half_t thalf_nxt [ortest_pkg::NUM_DIMS];
  ortest_pkg::half_t rdist [ortest_pkg::NUM_DIMS][ortest_pkg::NUM_CORNERS];
  ortest_pkg::half_t tdist [ortest_pkg::NUM_DIMS][ortest_pkg::NUM_CORNERS];
  ortest_pkg::edge_t r_lo, r_hi, t_lo, t_hi;
  logic              sep4_nxt;
  logic              sep4_r, sep5_r;

  function automatic ortest_pkg::half_t dist4(ortest_pkg::coord_t c, ortest_pkg::sum_t s);
    ortest_pkg::half_t d;
    d = (ortest_pkg::half_t'(c) <<< 2) - ortest_pkg::half_t'(s);
    return d[ortest_pkg::HALF_WIDTH-1] ? -d : d;
  endfunction

  function automatic ortest_pkg::half_t max4(ortest_pkg::half_t a, ortest_pkg::half_t b,
                                             ortest_pkg::half_t c, ortest_pkg::half_t d);
    ortest_pkg::half_t m0, m1;
    m0 = (a > b) ? a : b;
    m1 = (c > d) ? c : d;
    return (m0 > m1) ? m0 : m1;
  endfunction

  // stage 2: four times the center of each box
  always_comb begin
    for (int d = 0; d < ortest_pkg::NUM_DIMS; d++) begin
      rsum_nxt[d] = '0;
      tsum_nxt[d] = '0;
      for (int k = 0; k < ortest_pkg::NUM_CORNERS; k++) begin
        rsum_nxt[d] = rsum_nxt[d] + ortest_pkg::sum_t'(ref1_c[2*k+d]);
        tsum_nxt[d] = tsum_nxt[d] + ortest_pkg::sum_t'(tst1_c[2*k+d]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      rsum2_r <= rsum_nxt;
      tsum2_r <= tsum_nxt;
    end
  end

  // stage 3: half extents, largest corner distance from the center
  always_comb begin
    for (int d = 0; d < ortest_pkg::NUM_DIMS; d++) begin
      for (int k = 0; k < ortest_pkg::NUM_CORNERS; k++) begin
        rdist[d][k] = dist4(ref2_c[2*k+d], rsum2_r[d]);
        tdist[d][k] = dist4(tst2_c[2*k+d], tsum2_r[d]);
      end
      rhalf_nxt[d] = max4(rdist[d][0], rdist[d][1], rdist[d][2], rdist[d][3]);
      thalf_nxt[d] = max4(tdist[d][0], tdist[d][1], tdist[d][2], tdist[d][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      rhalf_r <= rhalf_nxt;
      thalf_r <= thalf_nxt;
      rsum3_r <= rsum2_r;
      tsum3_r <= tsum2_r;
    end
  end

  // stage 4: strictly apart on either dimension rejects
  always_comb begin
    sep4_nxt = 1'b0;
    for (int d = 0; d < ortest_pkg::NUM_DIMS; d++) begin
      r_lo = ortest_pkg::edge_t'(rsum3_r[d]) - ortest_pkg::edge_t'(rhalf_r[d]);
      r_hi = ortest_pkg::edge_t'(rsum3_r[d]) + ortest_pkg::edge_t'(rhalf_r[d]);
      t_lo = ortest_pkg::edge_t'(tsum3_r[d]) - ortest_pkg::edge_t'(thalf_r[d]);
      t_hi = ortest_pkg::edge_t'(tsum3_r[d]) + ortest_pkg::edge_t'(thalf_r[d]);
      if ((r_lo > t_hi) || (r_hi < t_lo)) begin
        sep4_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      sep4_r <= sep4_nxt;
    end
    // delay to line up with the axis lanes
    if (en.s5) begin
      sep5_r <= sep4_r;
    end
  end

  assign sep = sep5_r;

endmodule

FILE: rtl/core/oriented_rect_overlap_test.sv
// Top level: reference store, pipeline control, four axis lanes, box lane and merge.
//
// Oriented rectangle overlap test (2-D separating axis test).
// Input channel (in_valid/in_ready): one beat carries a command and four
// corners A..D in signed Q8.8. A load beat stores the rectangle as the
// reference at the accepting edge and yields no result. A test beat is
// checked against the reference held at the moment it is accepted, so a
// load followed directly by tests applies to those tests.
// Result channel (out_valid/out_ready): one beat per test, out_overlap = 1
// when the rectangles touch or intersect, in the order the tests arrived.
// Pipeline: six register stages (input, axis, dot products, spans,
// separation, merge); the input stage loads at the accepting edge itself.
// Throughput: one beat per cycle, limited by nothing but the handshake;
// every stage has its own valid bit, so bubbles collapse and in_ready is
// low only when all six stages hold a test and out_ready is low.
// Reset: the reference reads as a point at the origin, the pipeline empties.
// Stall: a held result keeps out_overlap steady while earlier stages keep
// filling.
module oriented_rect_overlap_test (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  ortest_pkg::coord_t in_corner_a_x,
  input  ortest_pkg::coord_t in_corner_a_y,
  input  ortest_pkg::coord_t in_corner_b_x,
  input  ortest_pkg::coord_t in_corner_b_y,
  input  ortest_pkg::coord_t in_corner_c_x,
  input  ortest_pkg::coord_t in_corner_c_y,
  input  ortest_pkg::coord_t in_corner_d_x,
  input  ortest_pkg::coord_t in_corner_d_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_overlap
);

  ortest_pkg::coord_t     in_rect [ortest_pkg::NUM_COORDS];
  ortest_pkg::coord_t     ref_r [ortest_pkg::NUM_COORDS];
  ortest_pkg::coord_t     r1_r [ortest_pkg::NUM_COORDS];
  ortest_pkg::coord_t     t1_r [ortest_pkg::NUM_COORDS];
  ortest_pkg::coord_t     r2_r [ortest_pkg::NUM_COORDS];
  ortest_pkg::coord_t     t2_r [ortest_pkg::NUM_COORDS];
  logic                   v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                   out_valid_r, out_overlap_r;
  logic                   en1, en6;
  ortest_pkg::ortest_en_t en;
  logic                   in_fire;
  logic [3:0]             axis_sep;
  logic                   box_sep;

  assign in_rect[ortest_pkg::IDX_AX] = in_corner_a_x;
  assign in_rect[ortest_pkg::IDX_AY] = in_corner_a_y;
  assign in_rect[ortest_pkg::IDX_BX] = in_corner_b_x;
  assign in_rect[ortest_pkg::IDX_BY] = in_corner_b_y;
  assign in_rect[ortest_pkg::IDX_CX] = in_corner_c_x;
  assign in_rect[ortest_pkg::IDX_CY] = in_corner_c_y;
  assign in_rect[ortest_pkg::IDX_DX] = in_corner_d_x;
  assign in_rect[ortest_pkg::IDX_DY] = in_corner_d_y;

  // a stage loads when it is empty or its successor loads
  assign en6   = !out_valid_r || out_ready;
  assign en.s5 = !v5_r || en6;
  assign en.s4 = !v4_r || en.s5;
  assign en.s3 = !v3_r || en.s4;
  assign en.s2 = !v2_r || en.s3;
  assign en1   = !v1_r || en.s2;

  assign in_ready = en1;
  assign in_fire  = in_valid && en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ortest_pkg::NUM_COORDS; i++) begin
        ref_r[i] <= '0;
      end
    end else if (in_fire && (in_command == ortest_pkg::CMD_LOAD)) begin
      ref_r <= in_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)   v1_r <= in_valid && (in_command == ortest_pkg::CMD_TEST);
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
      if (en.s5) v5_r <= v4_r;
      if (en6)   out_valid_r <= v5_r;
    end
  end

  // coordinate payload for the first two stages
  always_ff @(posedge clk) begin
    if (en1) begin
      r1_r <= ref_r;
      t1_r <= in_rect;
    end
    if (en.s2) begin
      r2_r <= r1_r;
      t2_r <= t1_r;
    end
  end

  // reference edges C-B and C-D
  ortest_axis_lane u_lane_ref_cb (
    .clk   (clk),
    .en    (en),
    .p_x   (r1_r[ortest_pkg::IDX_CX]),
    .p_y   (r1_r[ortest_pkg::IDX_CY]),
    .q_x   (r1_r[ortest_pkg::IDX_BX]),
    .q_y   (r1_r[ortest_pkg::IDX_BY]),
    .ref_c (r2_r),
    .tst_c (t2_r),
    .sep   (axis_sep[0])
  );

  ortest_axis_lane u_lane_ref_cd (
    .clk   (clk),
    .en    (en),
    .p_x   (r1_r[ortest_pkg::IDX_CX]),
    .p_y   (r1_r[ortest_pkg::IDX_CY]),
    .q_x   (r1_r[ortest_pkg::IDX_DX]),
    .q_y   (r1_r[ortest_pkg::IDX_DY]),
    .ref_c (r2_r),
    .tst_c (t2_r),
    .sep   (axis_sep[1])
  );

  // tested edges B-A and B-C
  ortest_axis_lane u_lane_tst_ba (
    .clk   (clk),
    .en    (en),
    .p_x   (t1_r[ortest_pkg::IDX_BX]),
    .p_y   (t1_r[ortest_pkg::IDX_BY]),
    .q_x   (t1_r[ortest_pkg::IDX_AX]),
    .q_y   (t1_r[ortest_pkg::IDX_AY]),
    .ref_c (r2_r),
    .tst_c (t2_r),
    .sep   (axis_sep[2])
  );

  ortest_axis_lane u_lane_tst_bc (
    .clk   (clk),
    .en    (en),
    .p_x   (t1_r[ortest_pkg::IDX_BX]),
    .p_y   (t1_r[ortest_pkg::IDX_BY]),
    .q_x   (t1_r[ortest_pkg::IDX_CX]),
    .q_y   (t1_r[ortest_pkg::IDX_CY]),
    .ref_c (r2_r),
    .tst_c (t2_r),
    .sep   (axis_sep[3])
  );

  ortest_box_lane u_box (
    .clk    (clk),
    .en     (en),
    .ref1_c (r1_r),
    .tst1_c (t1_r),
    .ref2_c (r2_r),
    .tst2_c (t2_r),
    .sep    (box_sep)
  );

  // merge: overlap unless the box test or any axis separates
  always_ff @(posedge clk) begin
    if (en6) begin
      out_overlap_r <= !box_sep && (axis_sep == '0);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == ortest_pkg::CMD_LOAD) |=> !v1_r)
    else $error("load beat entered the result pipeline");

  a_test_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == ortest_pkg::CMD_TEST) |=> v1_r)
    else $error("test beat lost at the input stage");

  a_load_stores: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == ortest_pkg::CMD_LOAD)
    |=> (ref_r[ortest_pkg::IDX_AX] == $past(in_corner_a_x))
        && (ref_r[ortest_pkg::IDX_DY] == $past(in_corner_d_y)))
    else $error("reference not updated by load beat");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r && !out_ready)
    else $error("input blocked while the pipeline has a bubble");

  a_box_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && en6 && box_sep |=> out_valid && !out_overlap)
    else $error("box rejection not reflected in result");

endmodule
